// ----- rtl/wpv_pkg.sv -----
package wpv_pkg;

  typedef logic [15:0] unit_t;

  localparam unit_t CH_SPACE  = 16'h0020;
  localparam unit_t CH_DQUOTE = 16'h0022;
  localparam unit_t CH_STAR   = 16'h002A;
  localparam unit_t CH_DOT    = 16'h002E;
  localparam unit_t CH_SLASH  = 16'h002F;
  localparam unit_t CH_ONE    = 16'h0031;
  localparam unit_t CH_NINE   = 16'h0039;
  localparam unit_t CH_COLON  = 16'h003A;
  localparam unit_t CH_LT     = 16'h003C;
  localparam unit_t CH_GT     = 16'h003E;
  localparam unit_t CH_QMARK  = 16'h003F;
  localparam unit_t CH_UP_A   = 16'h0041;
  localparam unit_t CH_UP_Z   = 16'h005A;
  localparam unit_t CH_BSLASH = 16'h005C;
  localparam unit_t CH_LO_A   = 16'h0061;
  localparam unit_t CH_LO_Z   = 16'h007A;
  localparam unit_t CH_PIPE   = 16'h007C;
  localparam unit_t CASE_DIFF = 16'h0020;

  localparam unit_t HI_SURR_MIN = 16'hD800;
  localparam unit_t HI_SURR_MAX = 16'hDBFF;
  localparam unit_t LO_SURR_MIN = 16'hDC00;
  localparam unit_t LO_SURR_MAX = 16'hDFFF;

  // reserved base names, first character in the lowest slot
  localparam logic [2:0][15:0] NAME_CON = {16'h004E, 16'h004F, 16'h0043};
  localparam logic [2:0][15:0] NAME_PRN = {16'h004E, 16'h0052, 16'h0050};
  localparam logic [2:0][15:0] NAME_AUX = {16'h0058, 16'h0055, 16'h0041};
  localparam logic [2:0][15:0] NAME_NUL = {16'h004C, 16'h0055, 16'h004E};
  localparam logic [2:0][15:0] NAME_COM = {16'h004D, 16'h004F, 16'h0043};
  localparam logic [2:0][15:0] NAME_LPT = {16'h0054, 16'h0050, 16'h004C};

  localparam logic [2:0] BASE_LEN3 = 3'd3;
  localparam logic [2:0] BASE_LEN4 = 3'd4;
  localparam logic [2:0] BASE_OVER = 3'd5;

  typedef struct packed {
    logic             valid;
    logic             last;
    unit_t            code;
  } step_req_t;

  typedef struct packed {
    logic             nonempty;
    logic             dot_seen;
    logic [2:0]       bcount;
    logic [3:0][15:0] bchars;
  } comp_t;

  function automatic unit_t to_upper(unit_t c);
    return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_DIFF : c;
  endfunction

  function automatic logic is_letter(unit_t c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic is_forbidden(unit_t c);
    return c < CH_SPACE || c == CH_LT || c == CH_GT || c == CH_DQUOTE ||
           c == CH_PIPE || c == CH_QMARK || c == CH_STAR || c == CH_SLASH ||
           c == CH_COLON;
  endfunction

  function automatic comp_t add_to_comp(comp_t s, unit_t c);
    comp_t r;
    r = s;
    r.nonempty = 1'b1;
    if (!s.dot_seen) begin
      if (c == CH_DOT) begin
        r.dot_seen = 1'b1;
      end else if (s.bcount < BASE_LEN4) begin
        r.bchars[s.bcount[1:0]] = to_upper(c);
        r.bcount = s.bcount + 3'd1;
      end else begin
        r.bcount = BASE_OVER;
      end
    end
    return r;
  endfunction

  function automatic logic comp_bad(comp_t s, unit_t last_c);
    logic dev3, dev4;
    dev3 = s.bcount == BASE_LEN3 &&
           (s.bchars[2:0] == NAME_CON || s.bchars[2:0] == NAME_PRN ||
            s.bchars[2:0] == NAME_AUX || s.bchars[2:0] == NAME_NUL);
    dev4 = s.bcount == BASE_LEN4 &&
           (s.bchars[2:0] == NAME_COM || s.bchars[2:0] == NAME_LPT) &&
           s.bchars[3] >= CH_ONE && s.bchars[3] <= CH_NINE;
    return !s.nonempty || last_c == CH_DOT || last_c == CH_SPACE || dev3 || dev4;
  endfunction

endpackage

// ----- rtl/wpv_core.sv -----
module wpv_core #(
  parameter int MAX_PATH_UNITS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wpv_pkg::step_req_t req,
  output logic              path_ok
);
  import wpv_pkg::*;

  localparam int POS_W = $clog2(MAX_PATH_UNITS + 2);
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PATH_UNITS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PATH_UNITS);
  localparam logic [POS_W-1:0] POS_MIN = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DRV = POS_W'(0);
  localparam logic [POS_W-1:0] POS_COL = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEP = POS_W'(2);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  comp_t            comp_r, comp_nxt, comp_p;
  unit_t            prev_r, prev_nxt;
  logic             expect_r, expect_nxt, expect_p;
  logic             failed_r, failed_nxt, failed_p;
  logic             final_bad;
  unit_t            c;

  always_comb begin
    c        = req.code;
    pos_inc  = (pos_r < POS_SAT) ? pos_r + POS_W'(1) : pos_r;
    comp_p   = comp_r;
    expect_p = expect_r;
    failed_p = failed_r;
    if (pos_r == POS_DRV) begin
      if (!is_letter(c)) failed_p = 1'b1;
    end else if (pos_r == POS_COL) begin
      if (c != CH_COLON) failed_p = 1'b1;
    end else if (pos_r == POS_SEP) begin
      if (c != CH_BSLASH) failed_p = 1'b1;
    end else if (expect_r) begin
      expect_p = 1'b0;
      if (c < LO_SURR_MIN || c > LO_SURR_MAX) failed_p = 1'b1;
      comp_p = add_to_comp(comp_r, c);
    end else if (c == CH_BSLASH) begin
      if (comp_bad(comp_r, prev_r)) failed_p = 1'b1;
      comp_p = '0;
    end else begin
      if (is_forbidden(c)) failed_p = 1'b1;
      if (c >= HI_SURR_MIN && c <= HI_SURR_MAX) expect_p = 1'b1;
      else if (c >= LO_SURR_MIN && c <= LO_SURR_MAX) failed_p = 1'b1;
      comp_p = add_to_comp(comp_r, c);
    end

    final_bad = failed_p || expect_p || pos_inc < POS_MIN || pos_inc > POS_MAX ||
                (pos_r > POS_SEP && comp_bad(comp_p, c));
    path_ok   = !final_bad;

    pos_nxt    = pos_r;
    comp_nxt   = comp_r;
    prev_nxt   = prev_r;
    expect_nxt = expect_r;
    failed_nxt = failed_r;
    if (req.valid) begin
      if (req.last) begin
        pos_nxt    = '0;
        comp_nxt   = '0;
        prev_nxt   = '0;
        expect_nxt = 1'b0;
        failed_nxt = 1'b0;
      end else begin
        pos_nxt    = pos_inc;
        comp_nxt   = comp_p;
        prev_nxt   = c;
        expect_nxt = expect_p;
        failed_nxt = failed_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      comp_r   <= '0;
      prev_r   <= '0;
      expect_r <= 1'b0;
      failed_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      comp_r   <= comp_nxt;
      prev_r   <= prev_nxt;
      expect_r <= expect_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- rtl/windows_path_validator_unit.sv -----
// Checks an absolute Windows path given as a stream of UTF-16 code units.
// Input channel (in_*): one code unit per request in in_tdata, with in_tlast
// high on the final unit of the path. Result channel (out_*): one request per
// path, bit 0 of out_tdata is 1 when the path is valid, 0 otherwise.
// A unit is taken into an input register and checked there against the running
// path state; a final unit loads the verdict into the output register, which
// drives out_tvalid. Throughput is one code unit per cycle, except while a
// final unit waits on an untaken verdict; each unit checked updates the path
// state (position, current component, surrogate and failure flags).
// Reset (synchronous, rst_n low) empties both registers and clears the path
// state, so the next unit starts a new path. While a verdict waits on a low
// out_tready, non-final units keep flowing; a final unit waits in the input
// register and in_tready drops until the verdict is taken.
module windows_path_validator_unit #(
  parameter int MAX_PATH_UNITS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // last_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] path_ok, [7:1] zero
);
  import wpv_pkg::*;

  logic      s1_valid_r;
  unit_t     s1_code_r;
  logic      s1_last_r;
  logic      out_valid_r;
  logic      out_ok_r;
  logic      adv;
  logic      core_ok;
  step_req_t req;

  assign adv       = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign req.valid = adv;
  assign req.last  = s1_last_r;
  assign req.code  = s1_code_r;

  wpv_core #(
    .MAX_PATH_UNITS(MAX_PATH_UNITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .path_ok(core_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_code_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_ok_r <= core_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_ok_r};

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_last_r |-> !out_valid_r || out_tready)
    else $error("verdict overwritten before delivery");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(adv && s1_last_r))
    else $error("verdict without a final unit");

  a_held_unit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_code_r) && $stable(s1_last_r))
    else $error("pending unit lost");

endmodule

// ----- test/path_verdict_checker.sv -----
`timescale 1ns / 1ps

module path_verdict_checker #(
  parameter int MAX_UNITS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // last_unit
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] path_ok, [7:1] zero
  output int          mismatches,
  output int          verdicts_owed
);

  import wpv_pkg::*;

  int unsigned seen_units;
  int          seg_len;
  unit_t       name_up [4];
  int          name_len;
  logic        dot_hit;
  unit_t       prior_unit;
  logic        need_low;
  logic        doomed;
  logic        verdicts_due [$];

  function automatic logic in_span(unit_t c, unit_t lo, unit_t hi);
    return c >= lo && c <= hi;
  endfunction

  function automatic logic illegal_char(unit_t c);
    return c < CH_SPACE || c == CH_LT || c == CH_GT || c == CH_DQUOTE || c == CH_PIPE ||
           c == CH_QMARK || c == CH_STAR || c == CH_SLASH || c == CH_COLON;
  endfunction

  function automatic void clear_segment();
    seg_len = 0;
    name_len = 0;
    dot_hit = 1'b0;
    foreach (name_up[i]) name_up[i] = '0;
  endfunction

  function automatic void clear_path();
    seen_units = 0;
    clear_segment();
    prior_unit = '0;
    need_low = 1'b0;
    doomed = 1'b0;
  endfunction

  function automatic void grow_segment(unit_t c);
    if (seg_len < 7) seg_len++;
    if (!dot_hit) begin
      if (c == CH_DOT) begin
        dot_hit = 1'b1;
      end else if (name_len < 4) begin
        name_up[name_len] = in_span(c, CH_LO_A, CH_LO_Z) ? c - CASE_DIFF : c;
        name_len++;
      end else begin
        name_len = 5;
      end
    end
  endfunction

  function automatic logic segment_rejected(unit_t tail);
    logic [2:0][15:0] trio;
    trio = {name_up[2], name_up[1], name_up[0]};
    if (seg_len == 0) return 1'b1;
    if (tail == CH_DOT || tail == CH_SPACE) return 1'b1;
    if (name_len == 3 && (trio == NAME_CON || trio == NAME_PRN || trio == NAME_AUX ||
                          trio == NAME_NUL)) return 1'b1;
    if (name_len == 4 && (trio == NAME_COM || trio == NAME_LPT) &&
        in_span(name_up[3], CH_ONE, CH_NINE)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void take_unit(unit_t c, logic fin);
    int unsigned at;
    at = seen_units;
    if (seen_units < MAX_UNITS + 1) seen_units++;
    if (at == 0) begin
      if (!(in_span(c, CH_UP_A, CH_UP_Z) || in_span(c, CH_LO_A, CH_LO_Z))) doomed = 1'b1;
    end else if (at == 1) begin
      if (c != CH_COLON) doomed = 1'b1;
    end else if (at == 2) begin
      if (c != CH_BSLASH) doomed = 1'b1;
    end else if (need_low) begin
      need_low = 1'b0;
      if (!in_span(c, LO_SURR_MIN, LO_SURR_MAX)) doomed = 1'b1;
      grow_segment(c);
    end else if (c == CH_BSLASH) begin
      if (segment_rejected(prior_unit)) doomed = 1'b1;
      clear_segment();
    end else begin
      if (illegal_char(c)) doomed = 1'b1;
      if (in_span(c, HI_SURR_MIN, HI_SURR_MAX)) need_low = 1'b1;
      else if (in_span(c, LO_SURR_MIN, LO_SURR_MAX)) doomed = 1'b1;
      grow_segment(c);
    end
    prior_unit = c;
    if (fin) begin
      if (need_low) doomed = 1'b1;
      if (seen_units < 4 || seen_units > MAX_UNITS) doomed = 1'b1;
      if (at >= 3 && segment_rejected(c)) doomed = 1'b1;
      verdicts_due.push_back(!doomed);
      clear_path();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t verdict_watch: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic want;
    if (!rst_n) begin
      clear_path();
      verdicts_due.delete();
    end else begin
      if (in_tvalid && in_tready) take_unit(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected verdict", out_tdata, 8'h00);
        end else begin
          want = verdicts_due.pop_front();
          if (out_tdata[0] !== want) report_mismatch("path_ok", out_tdata, {7'd0, want});
          if (out_tdata[7:1] !== 7'd0) report_mismatch("pad bits", out_tdata, {7'd0, want});
        end
      end
    end
    verdicts_owed <= verdicts_due.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

  import wpv_pkg::*;

  localparam int MAX_UNITS    = 1024;
  localparam int RANDOM_UNITS = 650;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RX_HOLD      = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [7:0]  out_tdata;
  int          mismatches;
  int          verdicts_owed;

  int          hold_asks = 0;
  int          holds_served = 0;
  int          quiet = 0;
  int          random_units = 0;
  logic        tx_calm = 1'b0;
  unit_t       path_buf [$];

  always #5 clk = ~clk;

  windows_path_validator_unit #(
    .MAX_PATH_UNITS(MAX_UNITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  path_verdict_checker #(
    .MAX_UNITS(MAX_UNITS)
  ) verdict_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .verdicts_owed(verdicts_owed)
  );

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_unit(input unit_t u, input logic fin);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= u;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = tx_calm ? 0 : idle_span();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_path();
    foreach (path_buf[i]) send_unit(path_buf[i], i == path_buf.size() - 1);
  endtask

  // sender stops until every verdict is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(unit_t'(s[i]));
  endtask

  task automatic add_name_unit();
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        path_buf.push_back(unit_t'(CH_UP_A + $urandom_range(0, 25)));
      end
      3, 4, 5: begin
        path_buf.push_back(unit_t'(CH_LO_A + $urandom_range(0, 25)));
      end
      6, 7: begin
        path_buf.push_back(unit_t'(CH_ONE - 1 + $urandom_range(0, 9)));
      end
      8: path_buf.push_back(CH_DOT);
      9: path_buf.push_back(CH_SPACE);
      10: path_buf.push_back(16'h002D);
      11: path_buf.push_back(unit_t'($urandom_range(16'h0080, 16'hD7FF)));
      12: path_buf.push_back(unit_t'($urandom_range(16'hE000, 16'hFFFF)));
      13: begin
        path_buf.push_back(unit_t'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
        path_buf.push_back(unit_t'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
      end
      default: begin
        path_buf.push_back(unit_t'($urandom_range(16'h0020, 16'h007E)));
      end
    endcase
  endtask

  task automatic add_device_name();
    string tags [6];
    string base;
    unit_t c;
    tags = '{"CON", "PRN", "AUX", "NUL", "COM", "LPT"};
    base = tags[$urandom_range(0, 5)];
    for (int i = 0; i < 3; i++) begin
      c = unit_t'(base[i]);
      if ($urandom_range(0, 1)) c = c + CASE_DIFF;
      path_buf.push_back(c);
    end
    if ((base == "COM" || base == "LPT") && $urandom_range(0, 3) != 0)
      path_buf.push_back(unit_t'(CH_ONE - 1 + $urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      2: push_text(".txt");
      3: path_buf.push_back(CH_DOT);
      4: path_buf.push_back(unit_t'(CH_LO_A + $urandom_range(0, 25)));
      5: path_buf.push_back(CH_SPACE);
      default: ;
    endcase
  endtask

  task automatic add_segment();
    if ($urandom_range(0, 3) == 0) begin
      add_device_name();
    end else begin
      repeat ($urandom_range(1, 6)) add_name_unit();
    end
  endtask

  function automatic unit_t defect_unit();
    case ($urandom_range(0, 6))
      0: return unit_t'($urandom_range(0, 31));
      1: begin
        case ($urandom_range(0, 7))
          0: return CH_LT;
          1: return CH_GT;
          2: return CH_DQUOTE;
          3: return CH_PIPE;
          4: return CH_QMARK;
          5: return CH_STAR;
          6: return CH_SLASH;
          default: return CH_COLON;
        endcase
      end
      2: return unit_t'($urandom_range(LO_SURR_MIN, LO_SURR_MAX));
      3: return unit_t'($urandom_range(HI_SURR_MIN, HI_SURR_MAX));
      4: return CH_BSLASH;
      5: return CH_DOT;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic build_random_path();
    int kind;
    int segs;
    path_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) path_buf.push_back(unit_t'($urandom_range(0, 16'hFFFF)));
    end else begin
      path_buf.push_back(unit_t'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) +
                                 $urandom_range(0, 25)));
      path_buf.push_back(CH_COLON);
      path_buf.push_back(CH_BSLASH);
      segs = $urandom_range(1, 4);
      for (int i = 0; i < segs; i++) begin
        if (i > 0) path_buf.push_back(CH_BSLASH);
        add_segment();
      end
      if ($urandom_range(0, 19) == 0) path_buf.push_back(CH_BSLASH);
      if (kind >= 75) path_buf.insert($urandom_range(0, path_buf.size()), defect_unit());
    end
  endtask

  task automatic build_long_path(input int len);
    path_buf.delete();
    push_text("C:\\");
    for (int i = 3; i < len; i++) begin
      if (i % 40 == 0) path_buf.push_back(CH_BSLASH);
      else path_buf.push_back(unit_t'(CH_LO_A + (i % 26)));
    end
  endtask

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : receiver
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_served != hold_asks) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else if ($urandom_range(0, 1)) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (1 + idle_span()) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    path_buf.delete();
    push_text("a:\\x");
    send_path();
    path_buf.delete();
    push_text("Z:\\");
    send_path();
    path_buf.delete();
    push_text("C:\\");
    path_buf.push_back(HI_SURR_MIN);
    send_path();
    path_buf.delete();
    push_text("C:\\");
    path_buf.push_back(16'hFFFF);
    path_buf.push_back(16'h0000);
    send_path();
    path_buf.delete();
    path_buf.push_back(CH_DOT);
    send_path();
    path_buf.delete();
    push_text("q:\\nul.txt\\a");
    send_path();
    drain();

    while (random_units < RANDOM_UNITS) begin
      tx_calm = ($urandom_range(0, 5) == 0);
      if (hold_asks == 0 && random_units >= 200) begin
        tx_calm = 1'b1;
        hold_asks <= hold_asks + 1;
      end
      build_random_path();
      send_path();
      random_units += path_buf.size();
      if ($urandom_range(0, 39) == 0) drain();
    end
    drain();

    tx_calm = 1'b0;
    build_long_path(MAX_UNITS);
    send_path();
    build_long_path(MAX_UNITS + 6);
    send_path();
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
